### hw/rtl/cgnc_pkg.sv
// Shared types and codes for the cell grid neighbor counter.
package cgnc_pkg;

  typedef enum logic [2:0] {
    OP_SET     = 3'd0,
    OP_CLEAR   = 3'd1,
    OP_QUERY   = 3'd2,
    OP_ENTRY   = 3'd3,
    OP_CLR_ALL = 3'd4,
    OP_PRUNE   = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    CFG_COLS = 2'd0,
    CFG_ROWS = 2'd1,
    CFG_WRAP = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    op_t         op;
    logic [5:0]  col;
    logic [5:0]  row;
    logic [11:0] entry_index;
  } in_t;

  typedef struct packed {
    logic        alive;
    logic [3:0]  neighbor_count;
    logic [5:0]  entry_col;
    logic [5:0]  entry_row;
    logic [12:0] live_total;
    logic        status;
  } out_t;

  typedef struct packed {
    logic [5:0] row;
    logic [5:0] col;
  } entry_t;

  // One neighbor position produced by the offset unit.
  typedef struct packed {
    logic       valid;
    logic       center;
    logic [6:0] ncol;
    logic [6:0] nrow;
  } nbr_t;

  typedef enum logic [3:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_SET_RD,
    ST_SET_CHK,
    ST_CLR_RD,
    ST_CLR_CHK,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_MOVE,
    ST_QRY,
    ST_QRY_END,
    ST_ENT_RD,
    ST_ENT_OUT,
    ST_PRUNE,
    ST_DONE
  } state_t;

endpackage

### hw/rtl/cell_grid_neighbor_counter_core.sv
// Top level of the cell grid neighbor counter: sequencer, grid and live list.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_stall   in_data (in_t)
//   out_     output     out_valid / out_stall out_data (out_t)
//   cfg_     input      cfg_we                cfg_index, cfg_wdata
//
// Each beat is worked on alone by a sequencer around one grid address unit
// that computes row * MAX_COLS + col for the grid memory read and write ports.
// From the accepting edge back to idle with the output free: a set reads
// the grid and writes grid and list for a dead cell, an unknown op or an
// out-of-range request goes straight to its result, a query makes nine
// grid reads, one per cycle, then drains and gives its result, a list read
// reads one entry, a clear searches the list for a live cell, entry by
// entry, and moves the last entry into the gap, a prune walks the list
// once and a clear-all sweeps the grid. After reset the same sweep clears
// the grid, with in_stall high; configuration writes are taken throughout.
// A finished result sits in the output register while the next beat is
// accepted; the sequencer only waits if that register is still stalled.
module cell_grid_neighbor_counter_core
  import cgnc_pkg::*;
#(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_t       out_data,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_wdata
);

  localparam int CELLS = MAX_COLS * MAX_ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(CELLS + 1);
  localparam logic [AW-1:0] LAST_A = AW'(CELLS - 1);
  localparam logic [AW-1:0] COLS_A = AW'(MAX_COLS);
  localparam logic [CW-1:0] CELLS_C = CW'(CELLS);

  // Configuration registers.
  logic [6:0] cols_r;
  logic [6:0] rows_r;
  logic       wrap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= 7'd20;
      rows_r <= 7'd20;
      wrap_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COLS: cols_r <= cfg_wdata;
        CFG_ROWS: rows_r <= cfg_wdata;
        CFG_WRAP: wrap_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Bounds in use, clamped to the range the grid supports.
  logic [6:0] cols_eff;
  logic [6:0] rows_eff;

  always_comb begin
    if (cols_r < 7'd3) begin
      cols_eff = 7'd3;
    end else if (32'(cols_r) > 32'(MAX_COLS)) begin
      cols_eff = 7'(MAX_COLS);
    end else begin
      cols_eff = cols_r;
    end
    if (rows_r < 7'd3) begin
      rows_eff = 7'd3;
    end else if (32'(rows_r) > 32'(MAX_ROWS)) begin
      rows_eff = 7'(MAX_ROWS);
    end else begin
      rows_eff = rows_r;
    end
  end

  // Sequencer state.
  state_t         state_r, state_nxt;
  in_t            item_r, item_nxt;
  out_t           res_r, res_nxt;
  out_t           out_r, out_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [CW-1:0]  idx_r, idx_nxt;
  logic [CW-1:0]  kept_r, kept_nxt;
  logic [AW-1:0]  sweep_r, sweep_nxt;
  logic           sweep_res_r, sweep_res_nxt;
  logic [3:0]     step_r, step_nxt;
  logic [3:0]     acc_r, acc_nxt;
  logic           pend_r, pend_nxt;
  logic           qv_r, qv_nxt;
  logic           qc_r, qc_nxt;

  // Memory ports.
  logic           g_we;
  logic [AW-1:0]  g_waddr;
  logic           g_wdata;
  logic           g_rdata;
  logic           l_we;
  logic [AW-1:0]  l_waddr;
  entry_t         l_wdata;
  logic [AW-1:0]  l_raddr;
  entry_t         l_rdata;

  // Shared address unit and its coordinate select.
  nbr_t           nbr;
  logic [6:0]     a_col;
  logic [6:0]     a_row;
  logic [AW-1:0]  addr_w;
  logic           in_inb;
  logic           ent_keep;
  logic [31:0]    eidx_w;
  logic [CW-1:0]  cnt_m1;

  cgnc_nbr_unit u_nbr (
    .col  (item_r.col),
    .row  (item_r.row),
    .cols (cols_eff),
    .rows (rows_eff),
    .wrap (wrap_r),
    .step (step_r),
    .nbr  (nbr)
  );

  always_comb begin
    if (state_r == ST_QRY) begin
      a_col = nbr.ncol;
      a_row = nbr.nrow;
    end else if (state_r == ST_PRUNE) begin
      a_col = {1'b0, l_rdata.col};
      a_row = {1'b0, l_rdata.row};
    end else begin
      a_col = {1'b0, item_r.col};
      a_row = {1'b0, item_r.row};
    end
  end

  assign addr_w   = AW'(a_row) * COLS_A + AW'(a_col);
  assign in_inb   = ({1'b0, in_data.col} < cols_eff) && ({1'b0, in_data.row} < rows_eff);
  assign ent_keep = ({1'b0, l_rdata.col} < cols_eff) && ({1'b0, l_rdata.row} < rows_eff);
  assign eidx_w   = 32'(item_r.entry_index);
  assign cnt_m1   = count_r - CW'(1);

  cgnc_ram #(.WIDTH(1), .DEPTH(CELLS), .AW(AW)) u_grid (
    .clk   (clk),
    .we    (g_we),
    .waddr (g_waddr),
    .wdata (g_wdata),
    .raddr (addr_w),
    .rdata (g_rdata)
  );

  cgnc_ram #(.WIDTH($bits(entry_t)), .DEPTH(CELLS), .AW(AW)) u_list (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_waddr),
    .wdata (l_wdata),
    .raddr (l_raddr),
    .rdata (l_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      sweep_r     <= '0;
      sweep_res_r <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      qv_r        <= 1'b0;
      qc_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      sweep_res_r <= sweep_res_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      qv_r        <= qv_nxt;
      qc_r        <= qc_nxt;
    end
    item_r <= item_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
    idx_r  <= idx_nxt;
    kept_r <= kept_nxt;
    step_r <= step_nxt;
    acc_r  <= acc_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    kept_nxt      = kept_r;
    sweep_nxt     = sweep_r;
    sweep_res_nxt = sweep_res_r;
    step_nxt      = step_r;
    acc_nxt       = acc_r;
    pend_nxt      = pend_r;
    qv_nxt        = qv_r;
    qc_nxt        = qc_r;
    g_we          = 1'b0;
    g_waddr       = addr_w;
    g_wdata       = 1'b0;
    l_we          = 1'b0;
    l_waddr       = idx_r[AW-1:0];
    l_wdata       = l_rdata;
    l_raddr       = idx_r[AW-1:0];
    in_stall      = 1'b1;

    unique case (state_r)
      ST_SWEEP: begin
        g_we      = 1'b1;
        g_waddr   = sweep_r;
        sweep_nxt = sweep_r + AW'(1);
        if (sweep_r == LAST_A) begin
          state_nxt = sweep_res_r ? ST_DONE : ST_IDLE;
        end
      end

      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          item_nxt = in_data;
          res_nxt  = '0;
          unique case (in_data.op)
            OP_SET:   state_nxt = in_inb ? ST_SET_RD : ST_DONE;
            OP_CLEAR: state_nxt = in_inb ? ST_CLR_RD : ST_DONE;
            OP_QUERY: state_nxt = in_inb ? ST_QRY : ST_DONE;
            OP_ENTRY: begin
              state_nxt = (32'(in_data.entry_index) < 32'(count_r)) ? ST_ENT_RD : ST_DONE;
            end
            OP_CLR_ALL: begin
              count_nxt     = '0;
              sweep_nxt     = '0;
              sweep_res_nxt = 1'b1;
              state_nxt     = ST_SWEEP;
            end
            OP_PRUNE: state_nxt = ST_PRUNE;
            default:  state_nxt = ST_DONE;
          endcase
          if (in_data.op == OP_SET || in_data.op == OP_CLEAR || in_data.op == OP_QUERY) begin
            res_nxt.status = !in_inb;
          end else if (in_data.op == OP_ENTRY) begin
            res_nxt.status = !(32'(in_data.entry_index) < 32'(count_r));
          end else if (in_data.op != OP_CLR_ALL && in_data.op != OP_PRUNE) begin
            res_nxt.status = 1'b1;
          end
          idx_nxt  = '0;
          kept_nxt = '0;
          pend_nxt = 1'b0;
          step_nxt = 4'd0;
          acc_nxt  = 4'd0;
          qv_nxt   = 1'b0;
          qc_nxt   = 1'b0;
        end
      end

      ST_SET_RD: state_nxt = ST_SET_CHK;

      ST_SET_CHK: begin
        if (!g_rdata && count_r < CELLS_C) begin
          g_we      = 1'b1;
          g_wdata   = 1'b1;
          l_we      = 1'b1;
          l_waddr   = count_r[AW-1:0];
          l_wdata   = '{row: item_r.row, col: item_r.col};
          count_nxt = count_r + CW'(1);
        end
        state_nxt = ST_DONE;
      end

      ST_CLR_RD: state_nxt = ST_CLR_CHK;

      ST_CLR_CHK: begin
        if (g_rdata) begin
          g_we      = 1'b1;
          state_nxt = ST_SRCH_RD;
        end else begin
          state_nxt = ST_DONE;
        end
      end

      ST_SRCH_RD: begin
        state_nxt = (idx_r < count_r) ? ST_SRCH_CMP : ST_DONE;
      end

      ST_SRCH_CMP: begin
        if (l_rdata.col == item_r.col && l_rdata.row == item_r.row) begin
          l_raddr   = cnt_m1[AW-1:0];
          state_nxt = ST_MOVE;
        end else begin
          idx_nxt   = idx_r + CW'(1);
          state_nxt = ST_SRCH_RD;
        end
      end

      ST_MOVE: begin
        l_we      = 1'b1;
        count_nxt = cnt_m1;
        state_nxt = ST_DONE;
      end

      ST_QRY: begin
        qv_nxt   = nbr.valid && !nbr.center;
        qc_nxt   = nbr.center;
        pend_nxt = 1'b1;
        if (pend_r) begin
          if (qc_r) begin
            res_nxt.alive = g_rdata;
          end
          if (qv_r) begin
            acc_nxt = acc_r + {3'd0, g_rdata};
          end
        end
        step_nxt = step_r + 4'd1;
        if (step_r == 4'd8) begin
          state_nxt = ST_QRY_END;
        end
      end

      ST_QRY_END: begin
        res_nxt.neighbor_count = acc_r + {3'd0, qv_r && g_rdata};
        state_nxt              = ST_DONE;
      end

      ST_ENT_RD: begin
        l_raddr   = eidx_w[AW-1:0];
        state_nxt = ST_ENT_OUT;
      end

      ST_ENT_OUT: begin
        res_nxt.entry_col = l_rdata.col;
        res_nxt.entry_row = l_rdata.row;
        state_nxt         = ST_DONE;
      end

      ST_PRUNE: begin
        // The entry read last cycle is kept in order or dropped from the grid.
        if (pend_r) begin
          if (ent_keep) begin
            l_we     = 1'b1;
            l_waddr  = kept_r[AW-1:0];
            kept_nxt = kept_r + CW'(1);
          end else begin
            g_we = 1'b1;
          end
        end
        if (idx_r < count_r) begin
          idx_nxt  = idx_r + CW'(1);
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            count_nxt = kept_r;
            state_nxt = ST_DONE;
          end
        end
      end

      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt            = res_r;
          out_nxt.live_total = 13'(count_r);
          out_valid_nxt      = 1'b1;
          state_nxt          = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CELLS_C)
    else $error("live count above grid size");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result loaded outside the done state");

  a_nbr_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.neighbor_count <= 4'd8)
    else $error("neighbor count above eight");

  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> state_r != ST_IDLE)
    else $error("sequencer stayed idle after an accepted beat");
`endif

endmodule

### hw/rtl/cgnc_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
module cgnc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/cgnc_nbr_unit.sv
// Neighbor offset unit: maps step 0..8 of a query to one neighbor position.
module cgnc_nbr_unit
  import cgnc_pkg::*;
(
  input  logic [5:0] col,
  input  logic [5:0] row,
  input  logic [6:0] cols,
  input  logic [6:0] rows,
  input  logic       wrap,
  input  logic [3:0] step,
  output nbr_t       nbr
);

  logic [1:0] dc;
  logic [1:0] dr;
  logic [6:0] c7;
  logic [6:0] r7;
  logic [6:0] cp1;
  logic [6:0] rp1;
  logic       vc;
  logic       vr;

  always_comb begin
    dc = 2'd1;
    dr = 2'd1;
    unique case (step)
      4'd0: begin dr = 2'd0; dc = 2'd0; end
      4'd1: begin dr = 2'd0; dc = 2'd1; end
      4'd2: begin dr = 2'd0; dc = 2'd2; end
      4'd3: begin dr = 2'd1; dc = 2'd0; end
      4'd4: begin dr = 2'd1; dc = 2'd1; end
      4'd5: begin dr = 2'd1; dc = 2'd2; end
      4'd6: begin dr = 2'd2; dc = 2'd0; end
      4'd7: begin dr = 2'd2; dc = 2'd1; end
      4'd8: begin dr = 2'd2; dc = 2'd2; end
      default: begin dr = 2'd1; dc = 2'd1; end
    endcase
  end

  assign c7  = {1'b0, col};
  assign r7  = {1'b0, row};
  assign cp1 = c7 + 7'd1;
  assign rp1 = r7 + 7'd1;

  always_comb begin
    vc = 1'b1;
    vr = 1'b1;
    nbr.ncol = c7;
    nbr.nrow = r7;
    unique case (dc)
      2'd0: begin
        if (col == 6'd0) begin
          nbr.ncol = cols - 7'd1;
          vc = wrap;
        end else begin
          nbr.ncol = c7 - 7'd1;
        end
      end
      2'd2: begin
        if (cp1 >= cols) begin
          nbr.ncol = 7'd0;
          vc = wrap;
        end else begin
          nbr.ncol = cp1;
        end
      end
      default: nbr.ncol = c7;
    endcase
    unique case (dr)
      2'd0: begin
        if (row == 6'd0) begin
          nbr.nrow = rows - 7'd1;
          vr = wrap;
        end else begin
          nbr.nrow = r7 - 7'd1;
        end
      end
      2'd2: begin
        if (rp1 >= rows) begin
          nbr.nrow = 7'd0;
          vr = wrap;
        end else begin
          nbr.nrow = rp1;
        end
      end
      default: nbr.nrow = r7;
    endcase
    nbr.center = (dc == 2'd1) && (dr == 2'd1);
    nbr.valid  = vc && vr;
  end

endmodule

### sim/testbench.sv
// Self-checking testbench for the cell grid neighbor counter core.
module testbench;
  import cgnc_pkg::*;

  localparam int MAXC = 64;
  localparam int MAXR = 64;
  localparam int NCELL = MAXC * MAXR;
  localparam int WATCHDOG_LIMIT = 40000;

  // Predicts the result of each beat from a private copy of grid, list and
  // registers, and keeps the expected results in arrival order.
  class grid_scoreboard;
    bit        live_map[NCELL];
    entry_t    live_entries[NCELL];
    int        live_cnt;
    int        cols_reg;
    int        rows_reg;
    bit        wrap_reg;
    out_t      pending_results[$];
    int        errors;

    function void reset_state();
      foreach (live_map[i]) live_map[i] = 1'b0;
      live_cnt = 0;
      cols_reg = 20;
      rows_reg = 20;
      wrap_reg = 1'b1;
      pending_results.delete();
      errors = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [6:0] value);
      case (idx)
        CFG_COLS: cols_reg = int'(value);
        CFG_ROWS: rows_reg = int'(value);
        CFG_WRAP: wrap_reg = value[0];
        default: ;
      endcase
    endfunction

    function int clamp_bound(int v, int maxv);
      if (v < 3) return 3;
      if (v > maxv) return maxv;
      return v;
    endfunction

    // Notes an accepted input beat and queues its expected result.
    function void note_beat(in_t beat);
      out_t res;
      int cols;
      int rows;
      int c;
      int r;
      int nc;
      int nr;
      int kept;
      bit inb;
      cols = clamp_bound(cols_reg, MAXC);
      rows = clamp_bound(rows_reg, MAXR);
      c = beat.col;
      r = beat.row;
      inb = (c < cols) && (r < rows);
      res = '0;
      case (beat.op)
        OP_SET: begin
          if (!inb) res.status = 1'b1;
          else if (!live_map[r * MAXC + c] && live_cnt < NCELL) begin
            live_map[r * MAXC + c] = 1'b1;
            live_entries[live_cnt] = '{row: 6'(r), col: 6'(c)};
            live_cnt++;
          end
        end
        OP_CLEAR: begin
          if (!inb) res.status = 1'b1;
          else if (live_map[r * MAXC + c]) begin
            live_map[r * MAXC + c] = 1'b0;
            for (int i = 0; i < live_cnt; i++) begin
              if (live_entries[i].col == c && live_entries[i].row == r) begin
                live_entries[i] = live_entries[live_cnt - 1];
                live_cnt--;
                break;
              end
            end
          end
        end
        OP_QUERY: begin
          if (!inb) res.status = 1'b1;
          else begin
            res.alive = live_map[r * MAXC + c];
            for (int dr = -1; dr <= 1; dr++) begin
              for (int dc = -1; dc <= 1; dc++) begin
                if (dr == 0 && dc == 0) continue;
                nc = c + dc;
                nr = r + dr;
                if (wrap_reg) begin
                  nc = (nc + cols) % cols;
                  nr = (nr + rows) % rows;
                end else if (nc < 0 || nr < 0 || nc >= cols || nr >= rows) begin
                  continue;
                end
                res.neighbor_count += live_map[nr * MAXC + nc];
              end
            end
          end
        end
        OP_ENTRY: begin
          if (beat.entry_index < live_cnt) begin
            res.entry_col = live_entries[beat.entry_index].col;
            res.entry_row = live_entries[beat.entry_index].row;
          end else begin
            res.status = 1'b1;
          end
        end
        OP_CLR_ALL: begin
          foreach (live_map[i]) live_map[i] = 1'b0;
          live_cnt = 0;
        end
        OP_PRUNE: begin
          kept = 0;
          for (int i = 0; i < live_cnt; i++) begin
            if (live_entries[i].col < cols && live_entries[i].row < rows) begin
              live_entries[kept] = live_entries[i];
              kept++;
            end else begin
              live_map[live_entries[i].row * MAXC + live_entries[i].col] = 1'b0;
            end
          end
          live_cnt = kept;
        end
        default: res.status = 1'b1;
      endcase
      res.live_total = 13'(live_cnt);
      pending_results = {pending_results, res};
    endfunction

    // Compares one accepted result beat with the oldest expectation.
    function void check_result(out_t got);
      out_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, got);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.alive !== want.alive || got.neighbor_count !== want.neighbor_count ||
          got.entry_col !== want.entry_col || got.entry_row !== want.entry_row ||
          got.live_total !== want.live_total || got.status !== want.status) begin
        $display("%0t: mismatch expected alive=%0d nbr=%0d ecol=%0d erow=%0d total=%0d st=%0d",
                 $time, want.alive, want.neighbor_count, want.entry_col, want.entry_row,
                 want.live_total, want.status);
        $display("%0t:          actual   alive=%0d nbr=%0d ecol=%0d erow=%0d total=%0d st=%0d",
                 $time, got.alive, got.neighbor_count, got.entry_col, got.entry_row,
                 got.live_total, got.status);
        errors++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  in_t        in_data;
  logic       out_valid;
  logic       out_stall;
  out_t       out_data;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [6:0] cfg_wdata;

  grid_scoreboard board;
  int  send_idle_pct;
  int  recv_stall_pct;
  bit  hold_off;
  int  quiet_cycles;

  cell_grid_neighbor_counter_core #(.MAX_COLS(MAXC), .MAX_ROWS(MAXR)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Receiver: stalls at random or during a hold-off, and checks each beat
  // taken at a clock edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_result(out_data);
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog: counts cycles with no beat accepted on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("cell_grid_neighbor_counter_core regression: fail");
      $finish;
    end
  end

  // Offers one beat, with an optional random idle gap before it, and holds it
  // until accepted; the model is updated at the accepting edge. Valid stays
  // high into the next beat unless an idle gap or a drain drops it.
  task automatic send_beat(in_t beat);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall);
    board.note_beat(beat);
  endtask

  task automatic send_op(op_t op, int c, int r, int idx);
    in_t beat;
    beat.op = op;
    beat.col = 6'(c);
    beat.row = 6'(r);
    beat.entry_index = 12'(idx);
    send_beat(beat);
  endtask

  // Waits for every expected result, then lets a clear-all's sweep finish.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (NCELL + 50) @(posedge clk);
  endtask

  task automatic write_cfg(cfg_idx_t idx, int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= 7'(value);
    @(posedge clk);
    board.write_reg(idx, 7'(value));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Random beat: mostly in-bounds sets, queries and clears anywhere within
  // the given bounds; list reads, prunes, rare clear-all and noise.
  task automatic send_random_beat(int cols, int rows);
    in_t beat;
    int  pick;
    beat = in_t'(27'($urandom));
    pick = $urandom_range(99);
    if (pick < 35) beat.op = OP_SET;
    else if (pick < 50) beat.op = OP_CLEAR;
    else if (pick < 75) beat.op = OP_QUERY;
    else if (pick < 88) beat.op = OP_ENTRY;
    else if (pick < 92) beat.op = OP_PRUNE;
    else if (pick < 93) beat.op = OP_CLR_ALL;
    else beat.op = op_t'($urandom_range(7));
    if ($urandom_range(9) < 8) begin
      beat.col = 6'($urandom_range(cols > 64 ? 63 : cols - 1));
      beat.row = 6'($urandom_range(rows > 64 ? 63 : rows - 1));
    end
    if ($urandom_range(9) < 8) beat.entry_index = 12'($urandom_range(board.live_cnt + 2));
    send_beat(beat);
  endtask

  initial begin
    int dims[6][3];
    board = new();
    board.reset_state();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_COLS;
    cfg_wdata = '0;
    hold_off = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: corners, wrap and border, duplicates, swap-remove, bad codes.
    send_op(OP_SET, 0, 0, 0);
    send_op(OP_SET, 19, 19, 0);
    send_op(OP_SET, 19, 0, 0);
    send_op(OP_SET, 0, 0, 0);
    send_op(OP_QUERY, 0, 0, 0);
    send_op(OP_QUERY, 0, 19, 0);
    send_op(OP_SET, 20, 5, 0);
    send_op(OP_QUERY, 63, 63, 0);
    send_op(OP_ENTRY, 0, 0, 0);
    send_op(OP_ENTRY, 0, 0, 3);
    send_op(OP_ENTRY, 0, 0, 4095);
    send_op(OP_CLEAR, 0, 0, 0);
    send_op(OP_ENTRY, 0, 0, 0);
    send_op(OP_CLEAR, 5, 5, 0);
    send_beat(in_t'({3'd6, 6'd1, 6'd1, 12'd0}));
    send_beat(in_t'({3'd7, 6'h3f, 6'h3f, 12'hfff}));
    drain();
    write_cfg(CFG_WRAP, 0);
    send_op(OP_QUERY, 0, 0, 0);
    send_op(OP_QUERY, 18, 18, 0);
    drain();
    // Shrink so a listed cell falls outside, then prune it away.
    write_cfg(CFG_COLS, 0);
    write_cfg(CFG_ROWS, 127);
    send_op(OP_QUERY, 2, 0, 0);
    send_op(OP_PRUNE, 0, 0, 0);
    send_op(OP_ENTRY, 0, 0, 0);
    send_op(OP_CLR_ALL, 0, 0, 0);
    drain();

    // Random phases, each under its own bounds and one of four idling modes.
    dims = '{'{64, 64, 1}, '{3, 3, 1}, '{8, 5, 0}, '{127, 2, 1}, '{20, 20, 0}, '{6, 40, 1}};
    for (int ph = 0; ph < 6; ph++) begin
      write_cfg(CFG_COLS, dims[ph][0]);
      write_cfg(CFG_ROWS, dims[ph][1]);
      write_cfg(CFG_WRAP, dims[ph][2]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      if (ph == 4) begin
        // The receiver holds off while beats keep coming, filling the block.
        fork
          begin
            hold_off = 1'b1;
            repeat (400) @(posedge clk);
            hold_off = 1'b0;
          end
          for (int k = 0; k < 105; k++) send_random_beat(dims[ph][0], dims[ph][1]);
        join
      end else begin
        for (int k = 0; k < 105; k++) send_random_beat(dims[ph][0], dims[ph][1]);
      end
      drain();
    end

    if (board.errors == 0 && board.pending_results.size() == 0) begin
      $display("cell_grid_neighbor_counter_core regression: pass");
    end else begin
      $display("cell_grid_neighbor_counter_core regression: fail");
    end
    $finish;
  end
endmodule
